### hw/rtl/itr_pkg.sv
// Shared types and constants for the interval timer update pipeline.
package itr_pkg;

   // Time unit ratios
   localparam logic [63:0] NS_PER_SEC   = 64'd1000000000;
   localparam logic [63:0] NS_PER_USEC  = 64'd1000;
   localparam logic [31:0] USEC_PER_SEC = 32'd1000000;

   // Bit count of the shift-subtract stages for the remainder by the period
   localparam int MOD_BITS = 64;

   // floor(2^64 / 1e9): ns times this, shifted down 64, is the whole seconds
   // or one short
   localparam logic [34:0] SEC_RECIP = 35'd18446744073;

   // ceil(2^40 / 1000): exact quotient by 1000 for any value below 2^30
   localparam logic [30:0] USEC_RECIP = 31'd1099511628;
   localparam int          USEC_SHIFT = 40;

   // Which case a timer word falls into
   typedef enum logic [1:0] {
      KIND_RUNNING  = 2'd0,  // value still above elapsed time
      KIND_DISARMED = 2'd1,  // value zero, nothing changes
      KIND_ONESHOT  = 2'd2,  // expired, period zero
      KIND_PERIODIC = 2'd3   // expired, reload from period
   } kind_type;

   // Side data that rides along with every word
   typedef struct packed {
      kind_type    kind;
      logic [31:0] value_sec;
      logic [19:0] value_usec;
      logic [31:0] period_sec;
      logic [19:0] period_usec;
   } info_type;

endpackage

### hw/rtl/interval_timer_remaining.sv
// Interval timer update: a fully pipelined datapath, one word per clock while the result side is not stalled.
//
// Takes a timer's remaining value and period (seconds plus microseconds) and
// an elapsed time in ns, and returns the updated remaining value with the
// period passed through. A new word is taken every cycle while the result side
// is not stalled; each word passes 76 register stages: 4 for input capture, ns
// conversion and case selection, 64 one-bit stages for the remainder by the
// period, one for the reload subtract, 6 to split the ns value into seconds
// (reciprocal multiply plus one correction step) and microseconds (exact
// reciprocal multiply), and the output register. A stall on the result side
// holds the whole pipeline in place, so the input is ready exactly when the
// result side is empty or being taken.
module interval_timer_remaining (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // value_sec[31:0], value_usec[51:32], period_sec[83:52],
   // period_usec[103:84], elapsed_ns[167:104]
   input  logic [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_value_sec[31:0], new_value_usec[51:32], out_period_sec[83:52],
   // out_period_usec[103:84]
   output logic [103:0] rsp_tdata
);

   localparam int MB = itr_pkg::MOD_BITS;
   localparam int BK = 6;  // split stages after the reload subtract
   localparam logic [31:0] RecipLo = itr_pkg::SEC_RECIP[31:0];
   localparam logic [2:0]  RecipHi = itr_pkg::SEC_RECIP[34:32];

   logic adv;

   // Stage A: input register
   logic        a_valid_ff;
   logic [31:0] a_vsec_ff, a_psec_ff;
   logic [19:0] a_vusec_ff, a_pusec_ff;
   logic [63:0] a_elapsed_ff;

   // Stage B: seconds scaled to microseconds
   logic        b_valid_ff;
   logic [51:0] b_vmul_ff, b_pmul_ff;
   logic [31:0] b_vsec_ff, b_psec_ff;
   logic [19:0] b_vusec_ff, b_pusec_ff;
   logic [63:0] b_elapsed_ff;

   // Stage C: nanosecond values
   logic        c_valid_ff;
   logic [63:0] c_value_ns_ff, c_period_ns_ff, c_elapsed_ff;
   logic [31:0] c_vsec_ff, c_psec_ff;
   logic [19:0] c_vusec_ff, c_pusec_ff;

   // Remainder stages, index 0 loaded by the case selection
   logic                 md_valid_ff  [0:MB];
   logic [63:0]          md_rem_ff    [0:MB];
   logic [63:0]          md_num_ff    [0:MB];
   logic [63:0]          md_period_ff [0:MB];
   logic [63:0]          md_work_ff   [0:MB];
   itr_pkg::info_type    md_info_ff   [0:MB];

   // Split stages, index 0 loaded by the reload subtract
   logic                 bk_valid_ff [0:BK];
   itr_pkg::info_type    bk_info_ff  [0:BK];
   logic [63:0]          bk_ns_ff;

   // Seconds estimate and correction
   logic [62:0] e1_plo_ff, e1_phi_ff;
   logic [66:0] e1_pxm_ff;
   logic [63:0] e1_ns_ff;
   logic [34:0] e2_q_ff;
   logic [63:0] e2_ns_ff;
   logic [63:0] e3_prod_ff;
   logic [34:0] e3_q_ff;
   logic [63:0] e3_ns_ff;
   logic [30:0] e4_rem_ff;
   logic [34:0] e4_q_ff;
   logic [29:0] e5_rem_ff;
   logic [34:0] e5_q_ff;
   logic [31:0] e6_sec_ff;
   logic [19:0] e6_usec_ff;

   // Output register
   logic        o_valid_ff;
   logic [31:0] o_sec_ff, o_psec_ff;
   logic [19:0] o_usec_ff, o_pusec_ff;

   // Whole pipeline moves unless the result word is stuck
   assign adv        = !o_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = {o_pusec_ff, o_psec_ff, o_usec_ff, o_sec_ff};

   // Front valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         md_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_tvalid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         md_valid_ff[0] <= c_valid_ff;
      end
   end

   // Case selection, combinational part of stage D
   logic [63:0]          d_diff, d_over;
   itr_pkg::kind_type    d_kind;
   always_comb begin
      d_diff = c_value_ns_ff - c_elapsed_ff;
      d_over = c_elapsed_ff - c_value_ns_ff;
      if (c_value_ns_ff > c_elapsed_ff) begin
         d_kind = itr_pkg::KIND_RUNNING;
      end else if (c_value_ns_ff == 64'd0) begin
         d_kind = itr_pkg::KIND_DISARMED;
      end else if (c_period_ns_ff == 64'd0) begin
         d_kind = itr_pkg::KIND_ONESHOT;
      end else begin
         d_kind = itr_pkg::KIND_PERIODIC;
      end
   end

   // Front payload: capture, scale, convert, classify
   always_ff @(posedge clock) begin
      if (adv) begin
         a_vsec_ff    <= req_tdata[31:0];
         a_vusec_ff   <= req_tdata[51:32];
         a_psec_ff    <= req_tdata[83:52];
         a_pusec_ff   <= req_tdata[103:84];
         a_elapsed_ff <= req_tdata[167:104];

         b_vmul_ff    <= 52'(a_vsec_ff) * 52'(itr_pkg::USEC_PER_SEC);
         b_pmul_ff    <= 52'(a_psec_ff) * 52'(itr_pkg::USEC_PER_SEC);
         b_vsec_ff    <= a_vsec_ff;
         b_psec_ff    <= a_psec_ff;
         b_vusec_ff   <= a_vusec_ff;
         b_pusec_ff   <= a_pusec_ff;
         b_elapsed_ff <= a_elapsed_ff;

         c_value_ns_ff  <= (64'(b_vmul_ff) + 64'(b_vusec_ff)) * itr_pkg::NS_PER_USEC;
         c_period_ns_ff <= (64'(b_pmul_ff) + 64'(b_pusec_ff)) * itr_pkg::NS_PER_USEC;
         c_elapsed_ff   <= b_elapsed_ff;
         c_vsec_ff      <= b_vsec_ff;
         c_psec_ff      <= b_psec_ff;
         c_vusec_ff     <= b_vusec_ff;
         c_pusec_ff     <= b_pusec_ff;

         md_rem_ff[0]    <= 64'd0;
         md_num_ff[0]    <= d_over;
         md_period_ff[0] <= c_period_ns_ff;
         md_work_ff[0]   <= d_diff;
         md_info_ff[0]   <= '{kind: d_kind, value_sec: c_vsec_ff,
                              value_usec: c_vusec_ff, period_sec: c_psec_ff,
                              period_usec: c_pusec_ff};
      end
   end

   // Remainder by the period, one bit per stage
   for (genvar i = 1; i <= MB; i++) begin : g_mod
      logic [63:0] trial;
      assign trial = {md_rem_ff[i-1][62:0], md_num_ff[i-1][63]};
      always_ff @(posedge clock) begin
         if (reset) begin
            md_valid_ff[i] <= 1'b0;
         end else if (adv) begin
            md_valid_ff[i] <= md_valid_ff[i-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            md_rem_ff[i]    <= (trial >= md_period_ff[i-1]) ?
                               trial - md_period_ff[i-1] : trial;
            md_num_ff[i]    <= {md_num_ff[i-1][62:0], 1'b0};
            md_period_ff[i] <= md_period_ff[i-1];
            md_work_ff[i]   <= md_work_ff[i-1];
            md_info_ff[i]   <= md_info_ff[i-1];
         end
      end
   end

   // Reload subtract or running difference into the seconds split
   always_ff @(posedge clock) begin
      if (reset) begin
         bk_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         bk_valid_ff[0] <= md_valid_ff[MB];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         bk_ns_ff      <= (md_info_ff[MB].kind == itr_pkg::KIND_RUNNING) ?
                          md_work_ff[MB] : md_period_ff[MB] - md_rem_ff[MB];
         bk_info_ff[0] <= md_info_ff[MB];
      end
   end

   // Valid bits and side data ride along the split stages
   for (genvar j = 1; j <= BK; j++) begin : g_bk
      always_ff @(posedge clock) begin
         if (reset) begin
            bk_valid_ff[j] <= 1'b0;
         end else if (adv) begin
            bk_valid_ff[j] <= bk_valid_ff[j-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            bk_info_ff[j] <= bk_info_ff[j-1];
         end
      end
   end

   // Partial products summed; top bits are the seconds estimate
   logic [98:0] e2_sum;
   assign e2_sum = 99'(e1_plo_ff) + ((99'(e1_phi_ff) + 99'(e1_pxm_ff)) << 32);

   // Seconds by reciprocal multiply, then microseconds of the leftover
   always_ff @(posedge clock) begin
      if (adv) begin
         // partial products of ns * floor(2^64 / 1e9)
         e1_plo_ff <= 63'(bk_ns_ff[31:0]) * 63'(RecipLo);
         e1_phi_ff <= 63'(bk_ns_ff[63:32]) * 63'(RecipLo);
         e1_pxm_ff <= 67'(bk_ns_ff) * 67'(RecipHi);
         e1_ns_ff  <= bk_ns_ff;

         // estimate is exact or one short
         e2_q_ff  <= e2_sum[98:64];
         e2_ns_ff <= e1_ns_ff;

         // estimate back in ns
         e3_prod_ff <= {29'd0, e2_q_ff} * itr_pkg::NS_PER_SEC;
         e3_q_ff    <= e2_q_ff;
         e3_ns_ff   <= e2_ns_ff;

         // leftover is below two seconds
         e4_rem_ff <= 31'(e3_ns_ff - e3_prod_ff);
         e4_q_ff   <= e3_q_ff;

         // one correction step
         if (e4_rem_ff >= 31'(itr_pkg::NS_PER_SEC)) begin
            e5_q_ff   <= e4_q_ff + 35'd1;
            e5_rem_ff <= 30'(e4_rem_ff - 31'(itr_pkg::NS_PER_SEC));
         end else begin
            e5_q_ff   <= e4_q_ff;
            e5_rem_ff <= e4_rem_ff[29:0];
         end

         // seconds wrap to 32 bits; microseconds truncated
         e6_sec_ff  <= e5_q_ff[31:0];
         e6_usec_ff <= 20'((61'(e5_rem_ff) * 61'(itr_pkg::USEC_RECIP))
                           >> itr_pkg::USEC_SHIFT);
      end
   end

   // Output word: computed value, or a direct copy for disarmed/one-shot
   itr_pkg::info_type fin;
   assign fin = bk_info_ff[BK];
   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (adv) begin
         o_valid_ff <= bk_valid_ff[BK];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         case (fin.kind)
            itr_pkg::KIND_DISARMED: begin
               o_sec_ff  <= fin.value_sec;
               o_usec_ff <= fin.value_usec;
            end
            itr_pkg::KIND_ONESHOT: begin
               o_sec_ff  <= fin.period_sec;
               o_usec_ff <= fin.period_usec;
            end
            default: begin
               o_sec_ff  <= e6_sec_ff;
               o_usec_ff <= e6_usec_ff;
            end
         endcase
         o_psec_ff  <= fin.period_sec;
         o_pusec_ff <= fin.period_usec;
      end
   end

   // Remainder of a periodic word ends below its period
   a_mod_range: assert property (@(posedge clock) disable iff (reset)
      md_valid_ff[MB] && md_info_ff[MB].kind == itr_pkg::KIND_PERIODIC |->
      md_rem_ff[MB] < md_period_ff[MB])
      else $error("remainder not below period");

   // Seconds estimate is at most one short
   a_sec_est: assert property (@(posedge clock) disable iff (reset)
      bk_valid_ff[4] |-> 64'(e4_rem_ff) < (itr_pkg::NS_PER_SEC << 1))
      else $error("seconds estimate too far off");

   // Sub-second part left after the correction
   a_sec_range: assert property (@(posedge clock) disable iff (reset)
      bk_valid_ff[5] |-> 64'(e5_rem_ff) < itr_pkg::NS_PER_SEC)
      else $error("seconds split left too much");

   // Computed microseconds stay in range
   a_usec_range: assert property (@(posedge clock) disable iff (reset)
      bk_valid_ff[BK] |-> 32'(e6_usec_ff) < itr_pkg::USEC_PER_SEC)
      else $error("microseconds out of range");

   // A stall freezes the pipeline valid bits
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(md_valid_ff[MB]) && $stable(bk_valid_ff[0]) &&
               $stable(bk_valid_ff[BK]))
      else $error("pipeline moved during stall");

endmodule

### sim/tb_interval_timer_remaining.sv
// Self-checking testbench for the interval timer update pipeline.
module tb_interval_timer_remaining;

   localparam int  ITEM_COUNT  = 1650;
   localparam int  CYCLE_LIMIT = 300000;
   localparam int  DRAIN_WAIT  = 140;    // pipeline depth plus margin
   localparam int  HOLD_CYCLES = 500;    // long receiver hold-off, stalls the pipe
   localparam int  MAX_REPORTS = 10;
   localparam logic [63:0] NS_ALL = 64'hFFFF_FFFF_FFFF_FFFF;

   // One timer word in and one result word out
   typedef struct packed {
      logic [31:0] value_sec;
      logic [19:0] value_usec;
      logic [31:0] period_sec;
      logic [19:0] period_usec;
      logic [63:0] elapsed_ns;
   } timer_word_type;

   typedef struct packed {
      logic [31:0] new_sec;
      logic [19:0] new_usec;
      logic [31:0] per_sec;
      logic [19:0] per_usec;
   } update_word_type;

   // Directed row: a word, plus a hand-written result where it is obvious
   typedef struct {
      timer_word_type  word;
      bit              typed;
      update_word_type update;
   } directed_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [167:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;

   update_word_type pending_updates[$];
   int              mismatch_count;
   int              cycle_count;
   int              words_sent;
   bit              hold_done;
   int              hold_left;

   interval_timer_remaining u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 20-unit clock
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Seconds plus microseconds to nanoseconds
   function automatic logic [63:0] to_nanos(logic [31:0] sec, logic [19:0] usec);
      return ({32'd0, sec} * 64'd1000000 + {44'd0, usec}) * 64'd1000;
   endfunction

   // Expected update of one timer word
   function automatic update_word_type advance_timer(timer_word_type w);
      update_word_type u;
      logic [63:0]     value_ns;
      logic [63:0]     period_ns;
      logic [63:0]     left_ns;
      value_ns   = to_nanos(w.value_sec, w.value_usec);
      period_ns  = to_nanos(w.period_sec, w.period_usec);
      u.per_sec  = w.period_sec;
      u.per_usec = w.period_usec;
      u.new_sec  = w.value_sec;
      u.new_usec = w.value_usec;
      left_ns    = 64'd0;
      if (value_ns > w.elapsed_ns) begin
         left_ns = value_ns - w.elapsed_ns;
      end else if (value_ns != 64'd0) begin
         if (period_ns == 64'd0) begin
            u.new_sec  = w.period_sec;
            u.new_usec = w.period_usec;
         end else begin
            left_ns = period_ns - ((w.elapsed_ns - value_ns) % period_ns);
         end
      end
      if (left_ns != 64'd0) begin
         u.new_sec  = 32'(left_ns / 64'd1000000000);
         u.new_usec = 20'((left_ns % 64'd1000000000) / 64'd1000);
      end
      return u;
   endfunction

   function automatic timer_word_type make_word(logic [31:0] vs, logic [19:0] vu,
                                                logic [31:0] ps, logic [19:0] pu,
                                                logic [63:0] el);
      timer_word_type w;
      w.value_sec = vs; w.value_usec = vu;
      w.period_sec = ps; w.period_usec = pu;
      w.elapsed_ns = el;
      return w;
   endfunction

   function automatic update_word_type make_update(logic [31:0] ns, logic [19:0] nu,
                                                   logic [31:0] ps, logic [19:0] pu);
      update_word_type u;
      u.new_sec = ns; u.new_usec = nu; u.per_sec = ps; u.per_usec = pu;
      return u;
   endfunction

   // Random field helpers: mostly legal microseconds, sometimes the full 20 bits
   function automatic logic [19:0] rand_usec();
      if ($urandom_range(0, 7) == 0) return 20'($urandom);
      return 20'($urandom_range(0, 999999));
   endfunction

   function automatic logic [31:0] rand_sec();
      case ($urandom_range(0, 3))
         0: return 32'($urandom_range(0, 3));
         1: return 32'($urandom_range(0, 5000));
         default: return $urandom;
      endcase
   endfunction

   // Random timer word aimed at one of the update cases
   function automatic timer_word_type rand_word();
      timer_word_type w;
      logic [63:0]    value_ns;
      logic [63:0]    span;
      int             pick;
      pick = $urandom_range(0, 9);
      w = make_word(rand_sec(), rand_usec(), rand_sec(), rand_usec(),
                    {$urandom, $urandom});
      if ($urandom_range(0, 4) == 0) begin
         w.period_sec  = 32'd0;
         w.period_usec = ($urandom_range(0, 1) == 0) ? 20'd0 : rand_usec();
      end
      if (pick == 0) begin
         w.value_sec  = 32'd0;
         w.value_usec = 20'd0;
      end
      value_ns = to_nanos(w.value_sec, w.value_usec);
      if (value_ns != 64'd0) begin
         if (pick <= 3) begin
            // still running
            w.elapsed_ns = {$urandom, $urandom} % value_ns;
         end else if (pick == 4) begin
            // expires exactly now
            w.elapsed_ns = value_ns;
         end else begin
            // expired by some overshoot
            span = ($urandom_range(0, 1) == 0) ? 64'($urandom)
                                                : {$urandom, $urandom};
            w.elapsed_ns = (value_ns + span < value_ns) ? NS_ALL : value_ns + span;
         end
      end
      return w;
   endfunction

   directed_row_type directed_rows[12];

   initial begin
      directed_rows[0]  = '{make_word(32'd0, 20'd0, 32'd5, 20'd7, 64'd123), 1'b1,
                            make_update(32'd0, 20'd0, 32'd5, 20'd7)};
      directed_rows[1]  = '{make_word(32'd0, 20'd0, 32'hFFFF_FFFF, 20'd999999, NS_ALL),
                            1'b1,
                            make_update(32'd0, 20'd0, 32'hFFFF_FFFF, 20'd999999)};
      directed_rows[2]  = '{make_word(32'd10, 20'd500000, 32'd0, 20'd0,
                                      64'd1000000000), 1'b1,
                            make_update(32'd9, 20'd500000, 32'd0, 20'd0)};
      directed_rows[3]  = '{make_word(32'd1, 20'd0, 32'd0, 20'd0, 64'd1), 1'b1,
                            make_update(32'd0, 20'd999999, 32'd0, 20'd0)};
      directed_rows[4]  = '{make_word(32'd3, 20'd0, 32'd0, 20'd0, 64'd3000000000),
                            1'b1, make_update(32'd0, 20'd0, 32'd0, 20'd0)};
      directed_rows[5]  = '{make_word(32'd1, 20'd0, 32'd0, 20'd0, NS_ALL), 1'b1,
                            make_update(32'd0, 20'd0, 32'd0, 20'd0)};
      directed_rows[6]  = '{make_word(32'd1, 20'd0, 32'd2, 20'd0, 64'd1000000000),
                            1'b1, make_update(32'd2, 20'd0, 32'd2, 20'd0)};
      directed_rows[7]  = '{make_word(32'd1, 20'd0, 32'd2, 20'd0, 64'd2000000000),
                            1'b1, make_update(32'd1, 20'd0, 32'd2, 20'd0)};
      directed_rows[8]  = '{make_word(32'hFFFF_FFFF, 20'd999999, 32'hFFFF_FFFF,
                                      20'd999999, 64'd0), 1'b1,
                            make_update(32'hFFFF_FFFF, 20'd999999, 32'hFFFF_FFFF,
                                        20'd999999)};
      // microseconds above range: seconds wrap to zero
      directed_rows[9]  = '{make_word(32'hFFFF_FFFF, 20'hFFFFF, 32'd0, 20'hFFFFF,
                                      64'd0), 1'b1,
                            make_update(32'd0, 20'd48575, 32'd0, 20'hFFFFF)};
      directed_rows[10] = '{make_word(32'd0, 20'd1, 32'd0, 20'hFFFFF, NS_ALL), 1'b0,
                            '{default: '0}};
      directed_rows[11] = '{make_word(32'hFFFF_FFFF, 20'hFFFFF, 32'hFFFF_FFFF,
                                      20'hFFFFF, NS_ALL), 1'b0, '{default: '0}};
   end

   // Present one word and wait for it to be taken
   task automatic send_word(timer_word_type w, update_word_type expected);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {w.elapsed_ns, w.period_usec, w.period_sec, w.value_usec,
                     w.value_sec};
      do @(posedge clock); while (!req_tready);
      pending_updates.push_back(expected);
      words_sent++;
   endtask

   // Sender: directed table, then random words in bursts with gaps
   initial begin
      int             burst_left;
      int             gap;
      timer_word_type w;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      reset      = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].word,
                   directed_rows[i].typed ? directed_rows[i].update
                                          : advance_timer(directed_rows[i].word));
      end

      burst_left = 0;
      for (int n = 0; n < ITEM_COUNT; n++) begin
         if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
               @(negedge clock);
               req_tvalid <= 1'b0;
               repeat (gap - 1) @(negedge clock);
               @(posedge clock);
            end
            burst_left = $urandom_range(1, 40);
         end
         w = rand_word();
         send_word(w, advance_timer(w));
         burst_left--;
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain, then settle
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Receiver: own stall pattern, plus one long hold-off mid-run
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_done  <= 1'b0;
         hold_left  <= 0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!hold_done && words_sent > 400) begin
         rsp_tready <= 1'b0;
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
      end else if (cycle_count % 512 < 128) begin
         // stretch with no stalls
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Result checker
   always @(posedge clock) begin
      update_word_type want;
      update_word_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = make_update(rsp_tdata[31:0], rsp_tdata[51:32], rsp_tdata[83:52],
                           rsp_tdata[103:84]);
         if (pending_updates.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result word %h", rsp_tdata);
         end else begin
            want = pending_updates.pop_front();
            if (got != want) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"mismatch: exp sec %0d usec %0d psec %0d pusec %0d,",
                            " got sec %0d usec %0d psec %0d pusec %0d"},
                           want.new_sec, want.new_usec, want.per_sec,
                           want.per_usec, got.new_sec, got.new_usec,
                           got.per_sec, got.per_usec);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule
